[rtl/aeap_pkg.sv]
// Package for the ANSI escape attribute parser: byte codes, event codes,
// parser phases and the state and result structs.
// No dependencies; the parser top level, aeap_step and aeap_checker import it.
package aeap_pkg;

    // Byte codes recognized by the parser
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_BEL      = 8'h07;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_FF       = 8'h0C;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_DIGIT_0  = 8'h30;
    localparam logic [7:0] CH_DIGIT_9  = 8'h39;
    localparam logic [7:0] CH_FINAL_M  = 8'h6D;
    localparam logic [7:0] CH_FINAL_K  = 8'h4B;
    localparam logic [7:0] CH_FINAL_G  = 8'h47;
    localparam logic [7:0] CH_FINAL_T  = 8'h54;
    localparam logic [7:0] CH_FINAL_S  = 8'h73;
    localparam logic [7:0] CH_FINAL_U  = 8'h75;

    // Event codes on the result channel
    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_DRAW       = 4'd1;
    localparam logic [3:0] EV_BEEP       = 4'd2;
    localparam logic [3:0] EV_TAB        = 4'd3;
    localparam logic [3:0] EV_CLEAR      = 4'd4;
    localparam logic [3:0] EV_NEWLINE    = 4'd5;
    localparam logic [3:0] EV_RETURN     = 4'd6;
    localparam logic [3:0] EV_CLEAR_EOL  = 4'd7;
    localparam logic [3:0] EV_COLUMN     = 4'd8;
    localparam logic [3:0] EV_COLUMN_80  = 4'd9;
    localparam logic [3:0] EV_SAVE       = 4'd10;
    localparam logic [3:0] EV_RESTORE    = 4'd11;
    localparam logic [3:0] EV_LAST       = EV_RESTORE;

    // Parser phases; the spare code behaves as normal text
    localparam logic [1:0] PH_NORMAL = 2'd0;
    localparam logic [1:0] PH_ESC    = 2'd1;
    localparam logic [1:0] PH_CSI    = 2'd2;

    localparam logic [15:0] NUM_MAX = 16'hFFFF;

    typedef struct packed {
        logic       bold;
        logic       italic;
        logic       underline;
        logic       reverse;
        logic [3:0] fg;
        logic [3:0] bg;
    } attr_t;

    localparam attr_t ATTR_DEFAULT = '{
        bold: 1'b0, italic: 1'b0, underline: 1'b0, reverse: 1'b0,
        fg: 4'd0, bg: 4'd15
    };

    typedef struct packed {
        logic [1:0]  phase;
        logic [15:0] accum;
        attr_t       attr;
    } state_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [7:0]  char_code;
        logic [15:0] param_value;
        attr_t       attr;
    } result_t;

endpackage

[rtl/aeap_in_if.sv]
// Request channel of the parser: one text byte per request.
// Depends on nothing.
interface aeap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

[rtl/aeap_out_if.sv]
// Result channel of the parser: event, character, argument and attributes.
// Depends on nothing.
interface aeap_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [7:0]  char_code;
    logic [15:0] param_value;
    logic [3:0]  fg_index;
    logic [3:0]  bg_index;
    logic        bold_on;
    logic        italic_on;
    logic        underline_on;
    logic        reverse_on;

    modport source (
        output valid, input ready,
        output event_res, output char_code, output param_value,
        output fg_index, output bg_index,
        output bold_on, output italic_on, output underline_on, output reverse_on
    );
    modport sink (
        input valid, output ready,
        input event_res, input char_code, input param_value,
        input fg_index, input bg_index,
        input bold_on, input italic_on, input underline_on, input reverse_on
    );
endinterface

[rtl/ansi_escape_attribute_parser_unit.sv]
// Top level of the ANSI escape attribute parser: input register, parse step
// and result register. Uses aeap_pkg, aeap_in_if, aeap_out_if and aeap_step.
//
//   channel   direction   payload
//   -------   ---------   -------------------------------------------------
//   text      sink        text_byte
//   result    source      event_res, char_code, param_value, fg_index,
//                         bg_index, bold_on, italic_on, underline_on,
//                         reverse_on
//
// One request per cycle is accepted sustained while result.ready stays high; a
// result passes through the input register, then the result register.
// The parse state advances when a byte moves from the input register into
// the result register, so results come out in request order.
// A stalled result register holds its value; the input register still takes
// one more byte, and text.ready drops only when both are full.
// Reset (rst_n low) empties both registers and restores normal text, a zero
// number and the default attributes (black on white, all flags off).
module ansi_escape_attribute_parser_unit
    import aeap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    aeap_in_if.sink           text,
    aeap_out_if.source        result
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    state_t     state_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;

    state_t     st_next;
    result_t    step_res;
    logic       advance;
    logic       take_in;

    // Handshake: move the held byte forward when the result slot frees up
    assign advance = !out_valid_reg || result.ready;
    assign take_in = text.valid && text.ready;
    assign text.ready = !s1_valid_reg || advance;

    aeap_step u_step (
        .st        (state_reg),
        .text_byte (s1_byte_reg),
        .st_next   (st_next),
        .res       (step_res)
    );

    // Control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg.phase <= PH_NORMAL;
            state_reg.accum <= 16'd0;
            state_reg.attr  <= ATTR_DEFAULT;
        end
        else
        begin
            if (take_in)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_valid_reg && advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= st_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_byte_reg <= text.text_byte;
        end
        if (s1_valid_reg && advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.event_res    = out_res_reg.event_res;
    assign result.char_code    = out_res_reg.char_code;
    assign result.param_value  = out_res_reg.param_value;
    assign result.fg_index     = out_res_reg.attr.fg;
    assign result.bg_index     = out_res_reg.attr.bg;
    assign result.bold_on      = out_res_reg.attr.bold;
    assign result.italic_on    = out_res_reg.attr.italic;
    assign result.underline_on = out_res_reg.attr.underline;
    assign result.reverse_on   = out_res_reg.attr.reverse;

endmodule

[rtl/aeap_step.sv]
// Combinational parse step: current parser state and one byte in,
// next state and the result for that byte out. Uses aeap_pkg.
module aeap_step
    import aeap_pkg::*;
(
    input  state_t     st,
    input  logic [7:0] text_byte,
    output state_t     st_next,
    output result_t    res
);

    logic [19:0] accum_x10;
    logic        is_digit;
    logic        do_plain;
    logic [3:0]  ev;
    logic [7:0]  ch;
    logic [15:0] pv;

    // Foreground palette for codes 30..37
    function automatic logic [3:0] fg_map(input logic [2:0] idx);
        logic [3:0] r;
        unique case (idx)
            3'd0:    r = 4'd0;
            3'd1:    r = 4'd4;
            3'd2:    r = 4'd2;
            3'd3:    r = 4'd6;
            3'd4:    r = 4'd1;
            3'd5:    r = 4'd5;
            3'd6:    r = 4'd3;
            default: r = 4'd7;
        endcase
        return r;
    endfunction

    // Background palette for codes 40..47; white sits on the last code
    function automatic logic [3:0] bg_map(input logic [2:0] idx);
        logic [3:0] r;
        r = fg_map(idx);
        if (idx == 3'd7)
        begin
            r = 4'd15;
        end
        return r;
    endfunction

    // Apply one rendition number to the attributes
    function automatic attr_t rendition(input attr_t a, input logic [15:0] v);
        attr_t r;
        r = a;
        priority if (v == 16'd0)  r = ATTR_DEFAULT;
        else if (v == 16'd1)  r.bold      = 1'b1;
        else if (v == 16'd3)  r.italic    = 1'b1;
        else if (v == 16'd4)  r.underline = 1'b1;
        else if (v == 16'd7)  r.reverse   = 1'b1;
        else if (v == 16'd21) r.bold      = 1'b0;
        else if (v == 16'd23) r.italic    = 1'b0;
        else if (v == 16'd24) r.underline = 1'b0;
        else if (v == 16'd27) r.reverse   = 1'b0;
        else if (v >= 16'd30 && v <= 16'd37) r.fg = fg_map(3'(v - 16'd30));
        else if (v >= 16'd40 && v <= 16'd47) r.bg = bg_map(3'(v - 16'd40));
        return r;
    endfunction

    // accum * 10 + digit, wide enough that it cannot wrap
    assign accum_x10 = {1'b0, st.accum, 3'b000} + {3'b000, st.accum, 1'b0}
                     + {16'd0, text_byte[3:0]};
    assign is_digit  = (text_byte >= CH_DIGIT_0) && (text_byte <= CH_DIGIT_9);

    always_comb
    begin
        st_next  = st;
        do_plain = 1'b0;
        ev       = EV_NONE;
        ch       = 8'd0;
        pv       = 16'd0;

        // Escape and control-sequence phases; any other phase takes the normal-text path
        unique case (st.phase)
            PH_ESC:
            begin
                if (text_byte == CH_LBRACKET)
                begin
                    st_next.phase = PH_CSI;
                    st_next.accum = 16'd0;
                end
                else
                begin
                    do_plain = 1'b1;
                end
            end
            PH_CSI:
            begin
                if (is_digit)
                begin
                    st_next.accum = (accum_x10 > {4'd0, NUM_MAX}) ? NUM_MAX
                                                                  : accum_x10[15:0];
                end
                else
                begin
                    st_next.accum = 16'd0;
                    st_next.phase = PH_NORMAL;
                    priority if (text_byte == CH_SEMI)
                    begin
                        st_next.attr  = rendition(st.attr, st.accum);
                        st_next.phase = PH_CSI;
                    end
                    else if (text_byte == CH_FINAL_M)
                    begin
                        st_next.attr = rendition(st.attr, st.accum);
                    end
                    else if (text_byte == CH_FINAL_K)
                    begin
                        ev = EV_CLEAR_EOL;
                    end
                    else if (text_byte == CH_FINAL_G)
                    begin
                        ev = EV_COLUMN;
                        pv = st.accum;
                    end
                    else if (text_byte == CH_FINAL_T)
                    begin
                        ev = EV_COLUMN_80;
                        pv = st.accum;
                    end
                    else if (text_byte == CH_FINAL_S)
                    begin
                        ev = EV_SAVE;
                    end
                    else if (text_byte == CH_FINAL_U)
                    begin
                        ev = EV_RESTORE;
                    end
                end
            end
            default:
            begin
                do_plain = 1'b1;
            end
        endcase

        // Normal text, also the byte after a dropped ESC
        if (do_plain)
        begin
            st_next.phase = PH_NORMAL;
            unique case (text_byte)
                CH_NUL: ev = EV_NONE;
                CH_BEL: ev = EV_BEEP;
                CH_TAB: ev = EV_TAB;
                CH_FF:
                begin
                    ev           = EV_CLEAR;
                    st_next.attr = ATTR_DEFAULT;
                end
                CH_LF:  ev = EV_NEWLINE;
                CH_CR:  ev = EV_RETURN;
                CH_ESC:
                begin
                    ev            = EV_NONE;
                    st_next.phase = PH_ESC;
                end
                default:
                begin
                    ev = EV_DRAW;
                    ch = text_byte;
                end
            endcase
        end

        res.event_res   = ev;
        res.char_code   = ch;
        res.param_value = pv;
        res.attr        = st_next.attr;
    end

endmodule

[rtl/aeap_checker.sv]
// Port-level checks for the ANSI escape attribute parser, bound to the top
// level. Uses aeap_pkg for the event codes.
module aeap_checker
    import aeap_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  event_res,
    input logic [7:0]  char_code,
    input logic [15:0] param_value
);

    // A stalled result stays up
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // Event code stays within the defined set
    a_ev_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_res <= EV_LAST)
        else $error("undefined event code");

    // Character code only rides with a draw event
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_DRAW |-> char_code == 8'd0)
        else $error("char_code set on a non-draw event");

    // Argument only rides with the column moves
    a_param: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_COLUMN && event_res != EV_COLUMN_80
        |-> param_value == 16'd0)
        else $error("param_value set on an event without argument");

endmodule

bind ansi_escape_attribute_parser_unit aeap_checker u_aeap_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .event_res   (result.event_res),
    .char_code   (result.char_code),
    .param_value (result.param_value)
);
